// File: design/fir28_pkg.sv
// Shared widths, coefficient table and coefficient lookup for the 28-tap FIR filter.
package fir28_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 12;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int ACC_W    = 28;
  localparam int HALF_LEN = 14;
  localparam int TAPS_DEF = 28;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  localparam coef_t HALF_COEF [HALF_LEN] = '{
    12'sd9,   -12'sd48,  -12'sd22, 12'sd30,  12'sd37, -12'sd30,  -12'sd65,
    12'sd20,  12'sd105,  12'sd11,  -12'sd173, -12'sd98, 12'sd367, 12'sd846
  };

  // Symmetric coefficient of tap k; taps further than the half list from either end are zero.
  function automatic coef_t fir_coef(input int k, input int taps);
    int m;
    m = ((taps - 1 - k) < k) ? (taps - 1 - k) : k;
    if (m < 0 || m >= HALF_LEN) begin
      return '0;
    end
    return HALF_COEF[m];
  endfunction

endpackage

// File: design/fir28_sample_if.sv
// Valid/ready stream interfaces for input samples and filtered results.
interface fir28_sample_if
  import fir28_pkg::*;
();
  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface fir28_result_if
  import fir28_pkg::*;
();
  logic valid;
  logic ready;
  acc_t filtered;

  modport source (output valid, output filtered, input ready);
  modport sink   (input valid, input filtered, output ready);
endinterface

// File: design/fir_filter_28_tap.sv
// Top level of the symmetric FIR filter: transposed chain of tap cells and an output register.
// The result of a sample is presented from the output register in the cycle after its transfer.
// Throughput: one sample per cycle while results are taken; each cell does one constant multiply and add per transfer.
// The output register lets a new sample in while the previous result is being taken.
// Reset (rst_ni low, asynchronous) zeroes every partial sum, i.e. an all-zero sample history,
// and empties the output register.
module fir_filter_28_tap
  import fir28_pkg::*;
#(
  parameter int TAPS = TAPS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  fir28_sample_if.sink   in_i,
  fir28_result_if.source out_o
);

  localparam coef_t C0 = fir_coef(0, TAPS);

  logic                     in_xfer;
  logic signed [PROD_W-1:0] prod0;
  acc_t                     psum [1:TAPS];
  acc_t                     filtered_d;
  acc_t                     filtered_q;
  logic                     out_valid_q;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_xfer    = in_i.valid && in_i.ready;

  assign psum[TAPS] = '0;

  for (genvar k = 1; k < TAPS; k++) begin : g_tap
    fir28_tap_cell #(
      .COEF (fir_coef(k, TAPS))
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (in_xfer),
      .x_i    (in_i.sample),
      .psum_i (psum[k+1]),
      .psum_o (psum[k])
    );
  end

  assign prod0      = in_i.sample * C0;
  assign filtered_d = ACC_W'(prod0) + psum[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      filtered_q <= filtered_d;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.filtered = filtered_q;

endmodule

// File: design/fir28_tap_cell.sv
// One transposed-form tap: adds its coefficient times the new sample to its neighbour's partial sum.
module fir28_tap_cell
  import fir28_pkg::*;
#(
  parameter coef_t COEF = '0
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    adv_i,
  input  sample_t x_i,
  input  acc_t    psum_i,
  output acc_t    psum_o
);

  logic signed [PROD_W-1:0] prod;
  acc_t                     psum_d;
  acc_t                     psum_q;

  assign prod   = x_i * COEF;
  assign psum_d = ACC_W'(prod) + psum_i;
  assign psum_o = psum_q;

  // Partial sums stand in for the delay line, so zero at reset means an all-zero history.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      psum_q <= '0;
    end else if (adv_i) begin
      psum_q <= psum_d;
    end
  end

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the 28-tap symmetric FIR filter.
`timescale 1ns / 1ps

module testbench;
  import fir28_pkg::*;

  localparam int NTAPS       = 28;
  localparam int WEIGHT_LEN  = 14;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;

  localparam int signed TAP_WEIGHT [WEIGHT_LEN] = '{
    9, -48, -22, 30, 37, -30, -65, 20, 105, 11, -173, -98, 367, 846
  };

  typedef struct packed {
    sample_t sample;
    logic    typed;
    acc_t    filtered;
  } stim_row_t;

  // Opening rows: impulse after reset gives the first taps directly.
  localparam int NROWS = 22;
  localparam stim_row_t STIM_ROWS [NROWS] = '{
    '{16'sh7fff, 1'b1, 28'sd294903},
    '{16'sh0000, 1'b1, -28'sd1572816},
    '{16'sh0000, 1'b1, -28'sd720874},
    '{16'sh0000, 1'b1, 28'sd983010},
    '{16'sh8000, 1'b0, '0},
    '{16'shffff, 1'b0, '0},
    '{16'sh0001, 1'b0, '0},
    '{16'sh5555, 1'b0, '0},
    '{16'shaaaa, 1'b0, '0},
    '{16'sh8000, 1'b0, '0},
    '{16'sh8000, 1'b0, '0},
    '{16'sh8000, 1'b0, '0},
    '{16'sh7fff, 1'b0, '0},
    '{16'sh7fff, 1'b0, '0},
    '{16'sh7fff, 1'b0, '0},
    '{16'sh0100, 1'b0, '0},
    '{16'shfe00, 1'b0, '0},
    '{16'sh8000, 1'b0, '0},
    '{16'sh7fff, 1'b0, '0},
    '{16'sh8000, 1'b0, '0},
    '{16'sh7fff, 1'b0, '0},
    '{16'sh0000, 1'b0, '0}
  };

  logic clk_i;
  logic rst_ni;

  fir28_sample_if sample_ch ();
  fir28_result_if result_ch ();

  fir_filter_28_tap dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (sample_ch),
    .out_o  (result_ch)
  );

  sample_t     sample_history [NTAPS];
  acc_t        expected_filtered [$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int          sender_idle_pct;
  int          sink_idle_pct;
  bit          hold_pending;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // history[0] is the newest sample; older ones move up one tap per transfer
  function automatic acc_t shift_and_filter(input sample_t s);
    logic signed [47:0] sum;
    int m;
    for (int k = NTAPS - 1; k > 0; k--) begin
      sample_history[k] = sample_history[k-1];
    end
    sample_history[0] = s;
    sum = '0;
    for (int k = 0; k < NTAPS; k++) begin
      m = (NTAPS - 1 - k < k) ? NTAPS - 1 - k : k;
      if (m < WEIGHT_LEN) begin
        sum += $signed(sample_history[k]) * TAP_WEIGHT[m];
      end
    end
    return acc_t'(sum[ACC_W-1:0]);
  endfunction

  function automatic sample_t random_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return sample_t'($urandom_range(0, 16)) - 16'sd8;
      3: return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic send_sample(input sample_t s, input logic typed, input acc_t typed_value);
    acc_t predicted;
    sample_ch.valid  <= 1'b1;
    sample_ch.sample <= s;
    do @(posedge clk_i); while (!sample_ch.ready);
    predicted = shift_and_filter(s);
    expected_filtered.push_back(typed ? typed_value : predicted);
    if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      sample_ch.valid  <= 1'b0;
      sample_ch.sample <= sample_t'($urandom);
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // Stimulus and end of run
  initial begin
    foreach (sample_history[k]) sample_history[k] = '0;
    mismatch_count   = 0;
    sender_idle_pct  = 0;
    sink_idle_pct    = 0;
    hold_pending     = 1'b0;
    rst_ni           = 1'b0;
    sample_ch.valid  = 1'b0;
    sample_ch.sample = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NROWS; r++) begin
      send_sample(STIM_ROWS[r].sample, STIM_ROWS[r].typed, STIM_ROWS[r].filtered);
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct = 31;
          sink_idle_pct   = 50;
        end
        1: begin
          sender_idle_pct = 50;
          sink_idle_pct   = 31;
        end
        default: begin
          sender_idle_pct = 0;
          sink_idle_pct   = 0;
          hold_pending    = 1'b1;  // long sink stall with the source still offering
        end
      endcase
      for (int i = 0; i < ((phase == 2) ? 100 : 150); i++) begin
        send_sample(random_sample(), 1'b0, '0);
      end
    end
    sample_ch.valid <= 1'b0;

    while (expected_filtered.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[fir_filter_28_tap] OK");
    end else begin
      $display("[fir_filter_28_tap] ERROR");
    end
    $finish;
  end

  // Result sink and checker
  initial begin
    int unsigned hold_left;
    acc_t want;
    hold_left       = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (result_ch.valid && result_ch.ready) begin
        if (expected_filtered.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d",
                   $time, result_ch.filtered);
          mismatch_count++;
        end else begin
          want = expected_filtered.pop_front();
          if (result_ch.filtered !== want) begin
            $display("%0t: filtered mismatch, expected %0d, actual %0d",
                     $time, want, result_ch.filtered);
            mismatch_count++;
          end
        end
      end
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
    end
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("[fir_filter_28_tap] ERROR");
        $finish;
      end
    end
  end

endmodule
